FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on i_clk, disabled while i_rst_n is low.
`define DXQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Concurrent assertion on i_clk that also holds during reset.
`define DXQ_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/dxq_pkg.sv
// Types, codes and sizing constants of the deferred extent queue.
`default_nettype none

package dxq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int RES_CNT_W       = 6;
    localparam int LEN_W           = 21;
    localparam int TOTAL_W         = 26;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 26'h3FF_FFFF;

    localparam logic [1:0] ACT_ENQ   = 2'd0;
    localparam logic [1:0] ACT_TAKE  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [1:0] ST_ENQ  = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    typedef struct packed {
        logic [63:0]      start;
        logic [LEN_W-1:0] len;
        logic [63:0]      owner;
        logic [63:0]      offset;
        logic [7:0]       flags;
        logic             skip;
    } t_entry;

    typedef struct packed {
        logic [1:0]         status;
        t_entry             ext;
        logic               last;
        logic [TOTAL_W-1:0] pending;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/dxq_ring.sv
// Ring memory of queued extents: one write port, one registered read port.
`default_nettype none

module dxq_ring #(
    parameter int  QUEUE_DEPTH = dxq_pkg::QUEUE_DEPTH_DEF,
    localparam int AW          = $clog2(QUEUE_DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire dxq_pkg::t_entry i_wr_data,
    input  wire logic [AW-1:0]   i_rd_addr,
    output dxq_pkg::t_entry      o_rd_data
);

    dxq_pkg::t_entry r_mem [QUEUE_DEPTH];
    dxq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/dxq_ctrl.sv
// Command sequencer: ring pointers, pending total and extent piece generation.
`default_nettype none

module dxq_ctrl #(
    parameter int  QUEUE_DEPTH = dxq_pkg::QUEUE_DEPTH_DEF,
    localparam int AW          = $clog2(QUEUE_DEPTH),
    localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_action,
    input  wire dxq_pkg::t_entry             i_ext,
    input  wire logic                        i_out_free,
    output logic                             o_post,
    output dxq_pkg::t_result                 o_res,
    output logic                             o_wr_en,
    output logic [AW-1:0]                    o_wr_addr,
    output dxq_pkg::t_entry                  o_wr_data,
    output logic [AW-1:0]                    o_rd_addr,
    input  wire dxq_pkg::t_entry             i_rd_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam int LW = dxq_pkg::LEN_W;
    localparam int TW = dxq_pkg::TOTAL_W;
    localparam int NW = dxq_pkg::RES_CNT_W;

    logic [1:0]      r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [TW-1:0]   r_total, n_total;
    logic [1:0]      r_act, n_act;
    logic [LW-1:0]   r_left, n_left;
    logic [NW-1:0]   r_n, n_n;
    dxq_pkg::t_entry r_cmd, n_cmd;

    logic            partial;
    logic [LW-1:0]   piece_len;
    logic [TW-1:0]   total_sub;
    logic [TW:0]     total_sum;
    logic [CW-1:0]   count_after;
    logic [LW-1:0]   left_after;
    logic [NW-1:0]   n_after;
    logic            piece_last;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        next_slot = (idx == AW'(QUEUE_DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    // Piece arithmetic on the head entry that the ring shows this cycle.
    always_comb begin
        partial     = (r_act == dxq_pkg::ACT_TAKE) && (r_left < i_rd_data.len);
        piece_len   = partial ? r_left : i_rd_data.len;
        total_sub   = ({{(TW-LW){1'b0}}, piece_len} >= r_total)
                      ? '0 : r_total - {{(TW-LW){1'b0}}, piece_len};
        count_after = partial ? r_count : r_count - CW'(1);
        left_after  = r_left - piece_len;
        n_after     = r_n + NW'(1);
        if (r_act == dxq_pkg::ACT_TAKE) begin
            piece_last = (left_after == '0) || (count_after == '0);
        end else begin
            piece_last = (count_after == '0);
        end
        if (n_after == NW'(dxq_pkg::MAX_RESULTS)) begin
            piece_last = 1'b1;
        end
        total_sum = {1'b0, r_total} + {{(TW+1-LW){1'b0}}, r_left};
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_total   = r_total;
        n_act     = r_act;
        n_left    = r_left;
        n_n       = r_n;
        n_cmd     = r_cmd;
        o_post    = 1'b0;
        o_res     = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_tail;
        o_wr_data = r_cmd;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act   = i_action;
                    n_left  = i_ext.len;
                    n_cmd   = i_ext;
                    n_n     = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_out_free) begin
                    o_res.last = 1'b1;
                    n_state    = S_IDLE;
                    case (r_act)
                        dxq_pkg::ACT_ENQ: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                o_post        = 1'b1;
                                o_res.status  = dxq_pkg::ST_FULL;
                                o_res.pending = r_total;
                            end else begin
                                o_wr_en = 1'b1;
                                n_tail  = next_slot(r_tail);
                                n_count = r_count + CW'(1);
                                n_total = (total_sum > {1'b0, dxq_pkg::TOTAL_MAX})
                                          ? dxq_pkg::TOTAL_MAX : total_sum[TW-1:0];
                                o_post        = 1'b1;
                                o_res.status  = dxq_pkg::ST_ENQ;
                                o_res.pending = n_total;
                            end
                        end
                        dxq_pkg::ACT_TAKE: begin
                            if ((r_left == '0) || (r_count == '0)) begin
                                o_post        = 1'b1;
                                o_res.status  = dxq_pkg::ST_NONE;
                                o_res.pending = r_total;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        dxq_pkg::ACT_FLUSH: begin
                            if (r_count == '0) begin
                                n_total       = '0;
                                o_post        = 1'b1;
                                o_res.status  = dxq_pkg::ST_NONE;
                                o_res.pending = '0;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                            o_post        = 1'b1;
                            o_res.status  = dxq_pkg::ST_NONE;
                            o_res.pending = r_total;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_total = total_sub;
                    // A flush that drains the queue leaves the total at zero.
                    if ((r_act == dxq_pkg::ACT_FLUSH) && (count_after == '0)) begin
                        n_total = '0;
                    end
                    n_count = count_after;
                    n_left  = left_after;
                    n_n     = n_after;
                    if (partial) begin
                        o_wr_en         = 1'b1;
                        o_wr_addr       = r_head;
                        o_wr_data       = i_rd_data;
                        o_wr_data.start = i_rd_data.start + {{(64-LW){1'b0}}, r_left};
                        o_wr_data.len   = i_rd_data.len - r_left;
                    end else begin
                        n_head = next_slot(r_head);
                    end
                    o_post         = 1'b1;
                    o_res.status   = dxq_pkg::ST_EMIT;
                    o_res.ext      = i_rd_data;
                    o_res.ext.len  = piece_len;
                    o_res.last     = piece_last;
                    o_res.pending  = n_total;
                    if (piece_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_left <= n_left;
        r_n    <= n_n;
        r_cmd  <= n_cmd;
    end

    assign o_in_ready = (r_state == S_IDLE);
    // The ring reads the next head every cycle, so its registered data is the current head.
    assign o_rd_addr  = n_head;

endmodule

`default_nettype wire

FILE: rtl/core/deferred_extent_queue_unit.sv
// Top level of the deferred extent queue: sequencer, ring memory and result register.
//
//   channel | valid   | ready   | payload
//   request | i_valid | o_ready | i_action, i_start_block, i_length, i_owner, ...
//   result  | o_valid | i_ready | o_status, o_out_start_block, ..., o_pending_blocks
//
// An enqueue, a status-only request and a rejected enqueue post their result from
// the execute state. A take or flush emits its pieces from the emit state, as the
// single read port of the ring delivers one head extent per cycle unless stalled.
// Synchronous reset clears pointers, count and pending total; the ring is not cleared.
// A stalled result holds in the output register and the sequencer waits for it.
`default_nettype none

module deferred_extent_queue_unit #(
    parameter int QUEUE_DEPTH = dxq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [63:0] i_start_block,
    input  wire logic [20:0] i_length,
    input  wire logic [63:0] i_owner,
    input  wire logic [63:0] i_file_offset,
    input  wire logic [7:0]  i_owner_flags,
    input  wire logic        i_skip_discard,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [63:0]      o_out_start_block,
    output logic [20:0]      o_emit_length,
    output logic [63:0]      o_out_owner,
    output logic [63:0]      o_out_file_offset,
    output logic [7:0]       o_out_owner_flags,
    output logic             o_out_skip_discard,
    output logic             o_last,
    output logic [25:0]      o_pending_blocks
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    dxq_pkg::t_entry  in_ext;
    dxq_pkg::t_entry  wr_data;
    dxq_pkg::t_entry  rd_data;
    dxq_pkg::t_result post_res;
    dxq_pkg::t_result r_res;
    logic             post;
    logic             out_free;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        in_ext.start  = i_start_block;
        in_ext.len    = i_length;
        in_ext.owner  = i_owner;
        in_ext.offset = i_file_offset;
        in_ext.flags  = i_owner_flags;
        in_ext.skip   = i_skip_discard;
    end

    assign out_free = !r_out_valid || i_ready;

    dxq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_action   (i_action),
        .i_ext      (in_ext),
        .i_out_free (out_free),
        .o_post     (post),
        .o_res      (post_res),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    dxq_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (post) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (post) begin
            r_res <= post_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_res.status;
    assign o_out_start_block  = r_res.ext.start;
    assign o_emit_length      = r_res.ext.len;
    assign o_out_owner        = r_res.ext.owner;
    assign o_out_file_offset  = r_res.ext.offset;
    assign o_out_owner_flags  = r_res.ext.flags;
    assign o_out_skip_discard = r_res.ext.skip;
    assign o_last             = r_res.last;
    assign o_pending_blocks   = r_res.pending;

endmodule

`default_nettype wire

FILE: rtl/core/dxq_checker.sv
// Port-level checker of the deferred extent queue and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module dxq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_status,
    input wire logic [63:0] o_out_start_block,
    input wire logic [20:0] o_emit_length,
    input wire logic        o_last
);

    logic status_res;
    logic ext_clear;

    assign status_res = o_valid && (o_status != dxq_pkg::ST_EMIT);
    assign ext_clear  = (o_emit_length == '0) && (o_out_start_block == '0);

    // A stalled result must stay offered.
    `DXQ_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid, "result dropped while stalled")

    // Status-only results are always the single and final result of a request.
    `DXQ_ASSERT(a_status_last, status_res |-> o_last, "status result without last")

    `DXQ_ASSERT(a_status_zero, status_res |-> ext_clear, "status result carries extent data")

    // The block works on one request at a time.
    `DXQ_ASSERT(a_busy_after_accept, i_valid && o_ready |=> !o_ready, "request accepted while busy")

    `DXQ_ASSERT_NR(a_reset_idle, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind deferred_extent_queue_unit dxq_checker u_dxq_checker (.*);

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the deferred extent queue unit.
`timescale 1ns / 1ps

module tb;

    localparam int LEN_W        = dxq_pkg::LEN_W;
    localparam int TOTAL_W      = dxq_pkg::TOTAL_W;
    localparam int DEPTH        = dxq_pkg::QUEUE_DEPTH_DEF;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action       = dxq_pkg::ACT_NOP;
    logic [63:0]        i_start_block  = '0;
    logic [20:0]        i_length       = '0;
    logic [63:0]        i_owner        = '0;
    logic [63:0]        i_file_offset  = '0;
    logic [7:0]         i_owner_flags  = '0;
    logic               i_skip_discard = 1'b0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic [1:0]         o_status;
    logic [63:0]        o_out_start_block;
    logic [20:0]        o_emit_length;
    logic [63:0]        o_out_owner;
    logic [63:0]        o_out_file_offset;
    logic [7:0]         o_out_owner_flags;
    logic               o_out_skip_discard;
    logic               o_last;
    logic [25:0]        o_pending_blocks;

    deferred_extent_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_start_block      (i_start_block),
        .i_length           (i_length),
        .i_owner            (i_owner),
        .i_file_offset      (i_file_offset),
        .i_owner_flags      (i_owner_flags),
        .i_skip_discard     (i_skip_discard),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_out_start_block  (o_out_start_block),
        .o_emit_length      (o_emit_length),
        .o_out_owner        (o_out_owner),
        .o_out_file_offset  (o_out_file_offset),
        .o_out_owner_flags  (o_out_owner_flags),
        .o_out_skip_discard (o_out_skip_discard),
        .o_last             (o_last),
        .o_pending_blocks   (o_pending_blocks)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the extent ring, kept in step with every accepted request.
    logic [63:0]        ring_start  [DEPTH];
    logic [LEN_W-1:0]   ring_len    [DEPTH];
    logic [63:0]        ring_owner  [DEPTH];
    logic [63:0]        ring_offset [DEPTH];
    logic [7:0]         ring_flags  [DEPTH];
    logic               ring_skip   [DEPTH];
    int                 q_head      = 0;
    int                 q_tail      = 0;
    int                 q_count     = 0;
    logic [TOTAL_W-1:0] q_pending   = '0;
    dxq_pkg::t_result   outcome_fifo [$];

    int tx_idle_pct     = 30;
    int rx_idle_pct     = 30;
    int hold_token      = 0;
    int hold_token_seen = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int pieces_seen     = 0;
    int full_rejects    = 0;
    int partial_takes   = 0;
    int input_stalls    = 0;
    int mismatches      = 0;

    function automatic void drop_from_total(logic [LEN_W-1:0] n);
        if (TOTAL_W'(n) >= q_pending) q_pending = '0;
        else q_pending = q_pending - TOTAL_W'(n);
    endfunction

    function automatic dxq_pkg::t_result piece_of(int slot, logic [63:0] st,
                                                  logic [LEN_W-1:0] ln);
        dxq_pkg::t_result r;
        r.status     = dxq_pkg::ST_EMIT;
        r.ext.start  = st;
        r.ext.len    = ln;
        r.ext.owner  = ring_owner[slot];
        r.ext.offset = ring_offset[slot];
        r.ext.flags  = ring_flags[slot];
        r.ext.skip   = ring_skip[slot];
        r.last       = 1'b0;
        r.pending    = q_pending;
        return r;
    endfunction

    function automatic dxq_pkg::t_result status_only(logic [1:0] st);
        dxq_pkg::t_result r;
        r         = '0;
        r.status  = st;
        r.last    = 1'b1;
        r.pending = q_pending;
        return r;
    endfunction

    // Updates the shadow queue for one request and appends the results it must produce.
    function automatic void apply_request(logic [1:0] act, logic [63:0] start,
                                          logic [LEN_W-1:0] len, logic [63:0] owner,
                                          logic [63:0] offset, logic [7:0] flags,
                                          logic skip);
        dxq_pkg::t_result emitted [$];
        dxq_pkg::t_result final_res;
        logic [LEN_W-1:0] left;
        logic [TOTAL_W:0] sum;
        int               h;
        left = len;
        case (act)
            dxq_pkg::ACT_ENQ: begin
                if (q_count >= DEPTH) begin
                    emitted.push_back(status_only(dxq_pkg::ST_FULL));
                    full_rejects++;
                end else begin
                    ring_start[q_tail]  = start;
                    ring_len[q_tail]    = len;
                    ring_owner[q_tail]  = owner;
                    ring_offset[q_tail] = offset;
                    ring_flags[q_tail]  = flags;
                    ring_skip[q_tail]   = skip;
                    q_tail = (q_tail + 1) % DEPTH;
                    q_count++;
                    sum = {1'b0, q_pending} + (TOTAL_W + 1)'(len);
                    q_pending = (sum > dxq_pkg::TOTAL_MAX) ? dxq_pkg::TOTAL_MAX
                                                           : sum[TOTAL_W-1:0];
                    emitted.push_back(status_only(dxq_pkg::ST_ENQ));
                end
            end
            dxq_pkg::ACT_TAKE: begin
                while (left != 0 && q_count != 0 && emitted.size() < dxq_pkg::MAX_RESULTS) begin
                    h = q_head;
                    if (left < ring_len[h]) begin
                        // Only the leading part leaves; the head extent now starts past it.
                        drop_from_total(left);
                        emitted.push_back(piece_of(h, ring_start[h], left));
                        ring_start[h] = ring_start[h] + 64'(left);
                        ring_len[h]   = ring_len[h] - left;
                        left = '0;
                        partial_takes++;
                    end else begin
                        drop_from_total(ring_len[h]);
                        emitted.push_back(piece_of(h, ring_start[h], ring_len[h]));
                        left   = left - ring_len[h];
                        q_head = (q_head + 1) % DEPTH;
                        q_count--;
                    end
                end
            end
            dxq_pkg::ACT_FLUSH: begin
                while (q_count != 0 && emitted.size() < dxq_pkg::MAX_RESULTS) begin
                    h = q_head;
                    drop_from_total(ring_len[h]);
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                    if (q_count == 0) q_pending = '0;
                    emitted.push_back(piece_of(h, ring_start[h], ring_len[h]));
                end
                if (q_count == 0) q_pending = '0;
            end
            default: ;
        endcase
        if (emitted.size() == 0) emitted.push_back(status_only(dxq_pkg::ST_NONE));
        final_res = emitted.pop_back();
        final_res.last = 1'b1;
        emitted.push_back(final_res);
        foreach (emitted[i]) outcome_fifo.push_back(emitted[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic send_request(input logic [1:0] act, input logic [63:0] start,
                                input logic [LEN_W-1:0] len, input logic [63:0] owner,
                                input logic [63:0] offset, input logic [7:0] flags,
                                input logic skip);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 12) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_start_block  <= start;
        i_length       <= len;
        i_owner        <= owner;
        i_file_offset  <= offset;
        i_owner_flags  <= flags;
        i_skip_discard <= skip;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_request(act, start, len, owner, offset, flags, skip);
        requests_sent++;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_start();
        // Some extents sit just below the top of the block space so that splits wrap.
        if ($urandom_range(9) == 0) return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(255));
        return rand_word();
    endfunction

    function automatic logic [LEN_W-1:0] pick_extent_len();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 15) return LEN_MAX - LEN_W'($urandom_range(3));
        if (r < 25) return LEN_W'($urandom);
        return LEN_W'($urandom_range(1, 64));
    endfunction

    function automatic logic [LEN_W-1:0] pick_take_len();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 15) return LEN_MAX;
        if (r < 25) return LEN_W'($urandom);
        return LEN_W'($urandom_range(1, 160));
    endfunction

    task automatic enqueue_extent(input logic [63:0] start, input logic [LEN_W-1:0] len);
        send_request(dxq_pkg::ACT_ENQ, start, len, rand_word(), rand_word(), 8'($urandom),
                     1'($urandom));
    endtask

    task automatic issue_command(input logic [1:0] act, input logic [LEN_W-1:0] len);
        send_request(act, rand_word(), len, rand_word(), rand_word(), 8'($urandom),
                     1'($urandom));
    endtask

    task automatic test_directed_cases();
        issue_command(dxq_pkg::ACT_NOP, LEN_W'($urandom));
        issue_command(dxq_pkg::ACT_TAKE, 21'd5);
        issue_command(dxq_pkg::ACT_FLUSH, '0);
        send_request(dxq_pkg::ACT_ENQ, '1, LEN_MAX, '1, '1, 8'hFF, 1'b1);
        send_request(dxq_pkg::ACT_ENQ, '0, '0, '0, '0, 8'h00, 1'b0);
        send_request(dxq_pkg::ACT_ENQ, 64'd100, 21'd10, 64'h0123_4567_89AB_CDEF,
                     64'hFEDC_BA98_7654_3210, 8'h5A, 1'b0);
        issue_command(dxq_pkg::ACT_TAKE, '0);
        // Splits the first extent, whose start then wraps to zero.
        issue_command(dxq_pkg::ACT_TAKE, 21'd1);
        // Rest of the first extent, the empty one whole, and one block of the third.
        issue_command(dxq_pkg::ACT_TAKE, LEN_MAX);
        issue_command(dxq_pkg::ACT_NOP, '0);
        enqueue_extent(rand_word(), '0);
        issue_command(dxq_pkg::ACT_FLUSH, LEN_MAX);
        issue_command(dxq_pkg::ACT_FLUSH, '0);
    endtask

    task automatic test_full_queue();
        while (q_count < DEPTH) enqueue_extent(pick_start(), LEN_MAX);
        enqueue_extent(rand_word(), LEN_W'($urandom));
        enqueue_extent(rand_word(), '0);
        issue_command(dxq_pkg::ACT_TAKE, LEN_MAX);
        issue_command(dxq_pkg::ACT_FLUSH, '0);
        while (q_count < DEPTH) enqueue_extent(pick_start(), LEN_W'($urandom_range(0, 8)));
        // Asks for more than is queued: every entry comes out, then the take stops.
        issue_command(dxq_pkg::ACT_TAKE, LEN_MAX);
        issue_command(dxq_pkg::ACT_TAKE, 21'd3);
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        hold_token <= hold_token + 1;
        repeat (24) begin
            if ($urandom_range(1) == 0 || q_count == 0)
                enqueue_extent(pick_start(), pick_extent_len());
            else
                issue_command(dxq_pkg::ACT_TAKE, pick_take_len());
        end
        tx_idle_pct = 30;
    endtask

    task automatic test_random_traffic(input int count);
        int r;
        int target;
        target = 0;
        for (int k = 0; k < count; k++) begin
            if (k == 0) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            if (k == count / 4) begin
                tx_idle_pct = 30;
                rx_idle_pct <= 30;
            end
            // A moving fill target lets the queue swing between empty and full.
            if (k % 40 == 0) target = $urandom_range(DEPTH);
            r = $urandom_range(99);
            if (r < 3)
                issue_command(dxq_pkg::ACT_NOP, LEN_W'($urandom));
            else if (r < 6)
                issue_command(dxq_pkg::ACT_FLUSH, LEN_W'($urandom));
            else if ((q_count < target) ? (r < 25) : (r < 75))
                issue_command(dxq_pkg::ACT_TAKE, pick_take_len());
            else
                enqueue_extent(pick_start(), pick_extent_len());
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        dxq_pkg::t_result want;
        if (o_valid && i_ready) begin
            results_checked++;
            if (o_status == dxq_pkg::ST_EMIT) pieces_seen++;
            if (outcome_fifo.size() == 0) begin
                report_mismatch("result with none expected, status", 64'(o_status), '0);
            end else begin
                want = outcome_fifo.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_out_start_block !== want.ext.start)
                    report_mismatch("out_start_block", o_out_start_block, want.ext.start);
                if (o_emit_length !== want.ext.len)
                    report_mismatch("emit_length", 64'(o_emit_length), 64'(want.ext.len));
                if (o_out_owner !== want.ext.owner)
                    report_mismatch("out_owner", o_out_owner, want.ext.owner);
                if (o_out_file_offset !== want.ext.offset)
                    report_mismatch("out_file_offset", o_out_file_offset, want.ext.offset);
                if (o_out_owner_flags !== want.ext.flags)
                    report_mismatch("out_owner_flags", 64'(o_out_owner_flags),
                                    64'(want.ext.flags));
                if (o_out_skip_discard !== want.ext.skip)
                    report_mismatch("out_skip_discard", 64'(o_out_skip_discard),
                                    64'(want.ext.skip));
                if (o_last !== want.last)
                    report_mismatch("last", 64'(o_last), 64'(want.last));
                if (o_pending_blocks !== want.pending)
                    report_mismatch("pending_blocks", 64'(o_pending_blocks),
                                    64'(want.pending));
            end
        end
        if (hold_token != hold_token_seen) begin
            hold_token_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (i_valid && !o_ready) input_stalls <= input_stalls + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("deferred_extent_queue_unit regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_queue();
        test_backpressure();
        test_random_traffic(190);
        i_valid <= 1'b0;
        while (outcome_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results for %0d requests, %0d of them extent pieces.",
                 results_checked, requests_sent, pieces_seen);
        $display("Saw %0d full-queue rejections, %0d split heads, %0d stalled request cycles.",
                 full_rejects, partial_takes, input_stalls);
        if (mismatches == 0) begin
            $display("deferred_extent_queue_unit regression: pass");
        end else begin
            $display("deferred_extent_queue_unit regression: fail");
        end
        $finish;
    end

endmodule
